FILE: rtl/tlc_pkg.sv
package tlc_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_BLOCK_BYTES_LOG2 = 3'd0;
  localparam logic [2:0] CFG_L1_SETS_LOG2     = 3'd1;
  localparam logic [2:0] CFG_L1_WAYS          = 3'd2;
  localparam logic [2:0] CFG_L2_SETS_LOG2     = 3'd3;
  localparam logic [2:0] CFG_L2_WAYS          = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Reset values of the registers
  localparam logic [2:0] RST_BLOCK_BYTES_LOG2 = 3'd6;
  localparam logic [2:0] RST_L1_SETS_LOG2     = 3'd3;
  localparam logic [4:0] RST_L1_WAYS          = 5'd2;
  localparam logic [3:0] RST_L2_SETS_LOG2     = 4'd7;
  localparam logic [4:0] RST_L2_WAYS          = 5'd8;

  localparam int            WAY_W    = 5;
  localparam int            RANK_W   = 4;
  localparam logic [3:0]    RANK_MAX = 4'd15;
  localparam logic [4:0]    RANK_NONE = 5'd16;

  // Access time costs in ns
  localparam logic [9:0] T_ACCESS = 10'd1;
  localparam logic [9:0] T_L2     = 10'd20;
  localparam logic [9:0] T_MEM    = 10'd200;

  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [RANK_W-1:0] rank;
  } meta_t;

  // Status of one level's lookup engine
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
    logic ev_dirty;
  } lvl_stat_t;

  typedef enum logic [2:0] {
    LV_CLEAR,
    LV_IDLE,
    LV_SCAN,
    LV_DECIDE,
    LV_UPD,
    LV_DONE
  } lvl_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_L1,
    BK_L2_FIRST,
    BK_L2_SECOND,
    BK_OUT
  } back_state_t;

endpackage

FILE: rtl/tlc_front.sv
module tlc_front #(
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hold,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_pop,
  output logic                 q_valid,
  output logic                 q_kind,
  output logic [ADDR_BITS-1:0] q_addr
);

  logic                 kind_q [2];
  logic [ADDR_BITS-1:0] addr_q [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push;

  assign in_tready = (cnt_r != 2'd2) && !hold;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_kind    = kind_q[rd_ptr_r];
  assign q_addr    = addr_q[rd_ptr_r];

  // Advance queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the transaction, address cut to the used width
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r] <= in_tuser;
      addr_q[wr_ptr_r] <= ADDR_BITS'(in_tdata);
    end
  end

endmodule

FILE: rtl/tlc_level.sv
module tlc_level #(
  parameter int ADDR_BITS = 32,
  parameter int LINES     = 128,
  parameter int MAX_WAYS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  start,
  input  logic                  req_write,
  input  logic [ADDR_BITS-1:0]  req_addr,
  input  logic [2:0]            block_log2,
  input  logic [3:0]            sets_log2,
  input  logic [4:0]            ways,
  output tlc_pkg::lvl_stat_t    stat,
  output logic [ADDR_BITS-1:0]  ev_addr
);

  localparam int IW   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int FLOG = $clog2(LINES + 1) - 1;

  // Tag and state memories
  logic [ADDR_BITS-1:0] tag_mem  [LINES];
  tlc_pkg::meta_t       meta_mem [LINES];

  tlc_pkg::lvl_state_t  st_r, st_nxt;
  logic [IW-1:0]        clr_r, clr_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] tag_r, tag_nxt;
  logic [5:0]           sh_r, sh_nxt;
  logic [IW-1:0]        base_r, base_nxt;
  logic [4:0]           w_r, w_nxt;
  logic                 write_r, write_nxt;
  logic [4:0]           iss_r, iss_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [4:0]           chk_r, chk_nxt;
  logic                 hit_f_r, hit_f_nxt;
  logic [4:0]           hit_w_r, hit_w_nxt;
  logic [3:0]           hit_rank_r, hit_rank_nxt;
  logic                 inv_f_r, inv_f_nxt;
  logic [4:0]           inv_w_r, inv_w_nxt;
  logic [4:0]           vic_w_r, vic_w_nxt;
  logic [3:0]           vic_rank_r, vic_rank_nxt;
  logic                 vic_dirty_r, vic_dirty_nxt;
  logic [ADDR_BITS-1:0] vic_tag_r, vic_tag_nxt;
  logic [4:0]           tgt_r, tgt_nxt;
  logic [4:0]           old_r, old_nxt;
  logic                 hit_res_r, hit_res_nxt;
  logic                 ev_dirty_r, ev_dirty_nxt;

  logic [ADDR_BITS-1:0] rd_tag_r;
  tlc_pkg::meta_t       rd_meta_r;

  logic [IW-1:0]        rd_addr, wa;
  logic                 we, tag_we;
  tlc_pkg::meta_t       wmeta;

  logic [4:0]           s_eff;
  logic [16:0]          cap;
  logic [4:0]           w_clamp, w_eff;
  logic [ADDR_BITS-1:0] set_full, set_mask;
  logic [IW-1:0]        set_idx;
  logic [IW+4:0]        base_prod;
  logic [5:0]           sh_c;
  logic [IW+5:0]        rd_sum, wr_sum;
  logic                 chk_last;
  tlc_pkg::meta_t       m;

  // Work out the geometry in use
  always_comb begin
    s_eff = ({1'b0, sets_log2} > 5'(FLOG)) ? 5'(FLOG) : {1'b0, sets_log2};
    cap   = 17'(LINES) >> s_eff;
    if (ways == 5'd0) begin
      w_clamp = 5'd1;
    end else if (ways > 5'(MAX_WAYS)) begin
      w_clamp = 5'(MAX_WAYS);
    end else begin
      w_clamp = ways;
    end
    w_eff     = ({12'd0, w_clamp} > cap) ? 5'(cap) : w_clamp;
    set_mask  = (ADDR_BITS'(1) << s_eff) - ADDR_BITS'(1);
    set_full  = (req_addr >> block_log2) & set_mask;
    set_idx   = IW'(set_full);
    base_prod = (IW+5)'(set_idx) * (IW+5)'(w_eff);
    sh_c      = 6'(block_log2) + 6'(s_eff);
  end

  assign rd_sum   = (IW+6)'(base_r) + (IW+6)'(iss_r);
  assign wr_sum   = (IW+6)'(base_r) + (IW+6)'(chk_r);
  assign chk_last = chk_v_r && (chk_r == w_r - 5'd1);
  assign m        = rd_meta_r;

  // Sequence the way scan and the rank update
  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    addr_nxt      = addr_r;
    tag_nxt       = tag_r;
    sh_nxt        = sh_r;
    base_nxt      = base_r;
    w_nxt         = w_r;
    write_nxt     = write_r;
    iss_nxt       = iss_r;
    chk_v_nxt     = 1'b0;
    chk_nxt       = chk_r;
    hit_f_nxt     = hit_f_r;
    hit_w_nxt     = hit_w_r;
    hit_rank_nxt  = hit_rank_r;
    inv_f_nxt     = inv_f_r;
    inv_w_nxt     = inv_w_r;
    vic_w_nxt     = vic_w_r;
    vic_rank_nxt  = vic_rank_r;
    vic_dirty_nxt = vic_dirty_r;
    vic_tag_nxt   = vic_tag_r;
    tgt_nxt       = tgt_r;
    old_nxt       = old_r;
    hit_res_nxt   = hit_res_r;
    ev_dirty_nxt  = ev_dirty_r;
    rd_addr       = rd_sum[IW-1:0];
    we            = 1'b0;
    tag_we        = 1'b0;
    wa            = wr_sum[IW-1:0];
    wmeta         = '0;

    unique case (st_r)
      tlc_pkg::LV_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        if (clr_r == IW'(LINES - 1)) begin
          st_nxt = tlc_pkg::LV_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      // Take a new request when idle or in the done cycle, so lookups can chain
      tlc_pkg::LV_IDLE, tlc_pkg::LV_DONE: begin
        st_nxt = tlc_pkg::LV_IDLE;
        if (start) begin
          addr_nxt  = req_addr;
          write_nxt = req_write;
          tag_nxt   = req_addr >> sh_c;
          sh_nxt    = sh_c;
          base_nxt  = base_prod[IW-1:0];
          w_nxt     = w_eff;
          iss_nxt   = 5'd0;
          hit_f_nxt = 1'b0;
          inv_f_nxt = 1'b0;
          st_nxt    = tlc_pkg::LV_SCAN;
        end
      end
      tlc_pkg::LV_SCAN: begin
        if (iss_r < w_r) begin
          iss_nxt   = iss_r + 5'd1;
          chk_v_nxt = 1'b1;
          chk_nxt   = iss_r;
        end
        if (chk_v_r) begin
          if (!hit_f_r && m.valid && (rd_tag_r == tag_r)) begin
            hit_f_nxt    = 1'b1;
            hit_w_nxt    = chk_r;
            hit_rank_nxt = m.rank;
          end
          if (!inv_f_r && !m.valid) begin
            inv_f_nxt = 1'b1;
            inv_w_nxt = chk_r;
          end
          if ((chk_r == 5'd0) || (m.rank > vic_rank_r)) begin
            vic_w_nxt     = chk_r;
            vic_rank_nxt  = m.rank;
            vic_dirty_nxt = m.dirty;
            vic_tag_nxt   = rd_tag_r;
          end
          if (chk_last) begin
            st_nxt = tlc_pkg::LV_DECIDE;
          end
        end
      end
      tlc_pkg::LV_DECIDE: begin
        hit_res_nxt = hit_f_r;
        priority if (hit_f_r) begin
          tgt_nxt      = hit_w_r;
          old_nxt      = {1'b0, hit_rank_r};
          ev_dirty_nxt = 1'b0;
        end else if (inv_f_r) begin
          tgt_nxt      = inv_w_r;
          old_nxt      = tlc_pkg::RANK_NONE;
          ev_dirty_nxt = 1'b0;
        end else begin
          tgt_nxt      = vic_w_r;
          old_nxt      = {1'b0, vic_rank_r};
          ev_dirty_nxt = vic_dirty_r;
        end
        iss_nxt = 5'd0;
        st_nxt  = tlc_pkg::LV_UPD;
      end
      tlc_pkg::LV_UPD: begin
        if (iss_r < w_r) begin
          iss_nxt   = iss_r + 5'd1;
          chk_v_nxt = 1'b1;
          chk_nxt   = iss_r;
        end
        if (chk_v_r) begin
          we    = 1'b1;
          wmeta = m;
          if (chk_r == tgt_r) begin
            wmeta.rank = '0;
            if (hit_res_r) begin
              wmeta.dirty = m.dirty | write_r;
            end else begin
              wmeta.valid = 1'b1;
              wmeta.dirty = write_r;
              tag_we      = 1'b1;
            end
          end else if (m.valid && ({1'b0, m.rank} < old_r) &&
                       (m.rank < tlc_pkg::RANK_MAX)) begin
            wmeta.rank = m.rank + 4'd1;
          end
          if (chk_last) begin
            st_nxt = tlc_pkg::LV_DONE;
          end
        end
      end
      default: begin
        st_nxt = tlc_pkg::LV_CLEAR;
      end
    endcase

    // Restart the invalidation sweep on a configuration write
    if (clear) begin
      st_nxt  = tlc_pkg::LV_CLEAR;
      clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= tlc_pkg::LV_CLEAR;
      clr_r   <= '0;
      chk_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    tag_r       <= tag_nxt;
    sh_r        <= sh_nxt;
    base_r      <= base_nxt;
    w_r         <= w_nxt;
    write_r     <= write_nxt;
    iss_r       <= iss_nxt;
    chk_r       <= chk_nxt;
    hit_f_r     <= hit_f_nxt;
    hit_w_r     <= hit_w_nxt;
    hit_rank_r  <= hit_rank_nxt;
    inv_f_r     <= inv_f_nxt;
    inv_w_r     <= inv_w_nxt;
    vic_w_r     <= vic_w_nxt;
    vic_rank_r  <= vic_rank_nxt;
    vic_dirty_r <= vic_dirty_nxt;
    vic_tag_r   <= vic_tag_nxt;
    tgt_r       <= tgt_nxt;
    old_r       <= old_nxt;
    hit_res_r   <= hit_res_nxt;
    ev_dirty_r  <= ev_dirty_nxt;
  end

  // Read and write the set memories
  always_ff @(posedge clk) begin
    rd_tag_r  <= tag_mem[rd_addr];
    rd_meta_r <= meta_mem[rd_addr];
    if (we) begin
      meta_mem[wa] <= wmeta;
    end
    if (tag_we) begin
      tag_mem[wa] <= tag_r;
    end
  end

  // Rebuild the victim's address from its tag and the request's low bits
  assign ev_addr = (vic_tag_r << sh_r) | (addr_r & ~({ADDR_BITS{1'b1}} << sh_r));

  assign stat.busy     = (st_r == tlc_pkg::LV_CLEAR);
  assign stat.done     = (st_r == tlc_pkg::LV_DONE);
  assign stat.hit      = hit_res_r;
  assign stat.ev_dirty = ev_dirty_r;

endmodule

FILE: rtl/tlc_back.sv
module tlc_back #(
  parameter int ADDR_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic                       q_kind,
  input  logic [ADDR_BITS-1:0]       q_addr,
  output logic                       q_pop,
  output logic                       l1_start,
  output logic                       l1_write,
  output logic [ADDR_BITS-1:0]       l1_addr,
  input  tlc_pkg::lvl_stat_t         l1_stat,
  input  logic [ADDR_BITS-1:0]       l1_ev_addr,
  output logic                       l2_start,
  output logic                       l2_write,
  output logic [ADDR_BITS-1:0]       l2_addr,
  input  tlc_pkg::lvl_stat_t         l2_stat,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tlc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  tlc_pkg::back_state_t st_r, st_nxt;
  logic                 kind_r, kind_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] ev_addr_r, ev_addr_nxt;
  logic                 l1hit_r, l1hit_nxt;
  logic                 ev_r, ev_nxt;
  logic                 rdh_r, rdh_nxt, rdm_r, rdm_nxt;
  logic                 wrh_r, wrh_nxt, wrm_r, wrm_nxt;
  logic [1:0]           wbs_r, wbs_nxt;
  logic                 ov_r, ov_nxt;
  logic [tlc_pkg::OUT_TDATA_W-1:0] od_r, od_nxt;
  logic                 cur_read;
  logic [1:0]           l2acc;
  logic [2:0]           mem;
  logic [9:0]           tm;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // Sum the access time
  always_comb begin
    l2acc = {1'b0, rdh_r | rdm_r} + {1'b0, wrh_r | wrm_r};
    mem   = {2'b0, rdm_r} + {2'b0, wrm_r} + {1'b0, wbs_r};
    tm    = tlc_pkg::T_ACCESS + tlc_pkg::T_L2 * 10'(l2acc) + tlc_pkg::T_MEM * 10'(mem);
  end

  // Step one transaction through L1 and up to two L2 accesses
  always_comb begin
    st_nxt      = st_r;
    kind_nxt    = kind_r;
    addr_nxt    = addr_r;
    ev_addr_nxt = ev_addr_r;
    l1hit_nxt   = l1hit_r;
    ev_nxt      = ev_r;
    rdh_nxt     = rdh_r;
    rdm_nxt     = rdm_r;
    wrh_nxt     = wrh_r;
    wrm_nxt     = wrm_r;
    wbs_nxt     = wbs_r;
    ov_nxt      = ov_r && !out_tready;
    od_nxt      = od_r;
    q_pop       = 1'b0;
    l1_start    = 1'b0;
    l1_write    = q_kind;
    l1_addr     = q_addr;
    l2_start    = 1'b0;
    l2_write    = 1'b0;
    l2_addr     = addr_r;
    cur_read    = 1'b0;

    unique case (st_r)
      tlc_pkg::BK_IDLE: begin
        if (q_valid && !l1_stat.busy && !l2_stat.busy) begin
          q_pop    = 1'b1;
          l1_start = 1'b1;
          kind_nxt = q_kind;
          addr_nxt = q_addr;
          rdh_nxt  = 1'b0;
          rdm_nxt  = 1'b0;
          wrh_nxt  = 1'b0;
          wrm_nxt  = 1'b0;
          wbs_nxt  = 2'd0;
          st_nxt   = tlc_pkg::BK_L1;
        end
      end
      tlc_pkg::BK_L1: begin
        if (l1_stat.done) begin
          l1hit_nxt   = l1_stat.hit;
          ev_nxt      = l1_stat.ev_dirty;
          ev_addr_nxt = l1_ev_addr;
          if (l1_stat.hit) begin
            st_nxt = tlc_pkg::BK_OUT;
          end else begin
            // Write miss reads first; read miss writes the victim first
            l2_start = 1'b1;
            if (kind_r || !l1_stat.ev_dirty) begin
              l2_addr = addr_r;
            end else begin
              l2_addr  = l1_ev_addr;
              l2_write = 1'b1;
            end
            st_nxt = tlc_pkg::BK_L2_FIRST;
          end
        end
      end
      tlc_pkg::BK_L2_FIRST: begin
        cur_read = kind_r || !ev_r;
        if (l2_stat.done) begin
          rdh_nxt = cur_read && l2_stat.hit;
          rdm_nxt = cur_read && !l2_stat.hit;
          wrh_nxt = !cur_read && l2_stat.hit;
          wrm_nxt = !cur_read && !l2_stat.hit;
          wbs_nxt = wbs_r + {1'b0, l2_stat.ev_dirty};
          if (ev_r) begin
            l2_start = 1'b1;
            if (kind_r) begin
              l2_addr  = ev_addr_r;
              l2_write = 1'b1;
            end else begin
              l2_addr = addr_r;
            end
            st_nxt = tlc_pkg::BK_L2_SECOND;
          end else begin
            st_nxt = tlc_pkg::BK_OUT;
          end
        end
      end
      tlc_pkg::BK_L2_SECOND: begin
        cur_read = !kind_r;
        if (l2_stat.done) begin
          if (cur_read) begin
            rdh_nxt = l2_stat.hit;
            rdm_nxt = !l2_stat.hit;
          end else begin
            wrh_nxt = l2_stat.hit;
            wrm_nxt = !l2_stat.hit;
          end
          wbs_nxt = wbs_r + {1'b0, l2_stat.ev_dirty};
          st_nxt  = tlc_pkg::BK_OUT;
        end
      end
      tlc_pkg::BK_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {6'd0, tm, wbs_r, wrm_r, wrh_r, rdm_r, rdh_r, ev_r, l1hit_r};
          st_nxt = tlc_pkg::BK_IDLE;
        end
      end
      default: begin
        st_nxt = tlc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tlc_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    addr_r    <= addr_nxt;
    ev_addr_r <= ev_addr_nxt;
    l1hit_r   <= l1hit_nxt;
    ev_r      <= ev_nxt;
    rdh_r     <= rdh_nxt;
    rdm_r     <= rdm_nxt;
    wrh_r     <= wrh_nxt;
    wrm_r     <= wrm_nxt;
    wbs_r     <= wbs_nxt;
    od_r      <= od_nxt;
  end

endmodule

FILE: rtl/two_level_lru_writeback_cache_unit.sv
// Tag model of a two-level set-associative write-back, write-allocate cache with
// LRU replacement. Each accepted access gives one result with its hit, miss and
// writeback flags and its access time. A lookup in a level walks the ways of the
// set one per cycle through that level's tag memory, first to search and then to
// rewrite ranks; an access costs the L1 lookup plus zero, one or two L2 lookups.
// Two accesses may wait in the input queue while one is at work and a result waits
// at the output. After reset and after every configuration write to a defined
// register both levels are invalidated by a sweep of their lines, during which
// in_tready is low.
module two_level_lru_writeback_cache_unit #(
  parameter int ADDR_BITS = 32,
  parameter int L1_LINES  = 128,
  parameter int L2_LINES  = 8192,
  parameter int MAX_WAYS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // address[31:0]
  input  logic        in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // l1_hit[0], l1_writeback[1], l2_read_hit[2], l2_read_miss[3],
  // l2_write_hit[4], l2_write_miss[5], l2_writebacks[7:6], access_time_ns[17:8]
  output logic [tlc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [2:0] blk_r, blk_nxt;
  logic [2:0] l1s_r, l1s_nxt;
  logic [4:0] l1w_r, l1w_nxt;
  logic [3:0] l2s_r, l2s_nxt;
  logic [4:0] l2w_r, l2w_nxt;
  logic       cfg_hit;

  logic                 q_pop, q_valid, q_kind;
  logic [ADDR_BITS-1:0] q_addr;
  logic                 l1_start, l1_write, l2_start, l2_write;
  logic [ADDR_BITS-1:0] l1_addr, l2_addr, l1_ev_addr, l2_ev_addr;
  tlc_pkg::lvl_stat_t   l1_stat, l2_stat;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    blk_nxt = blk_r;
    l1s_nxt = l1s_r;
    l1w_nxt = l1w_r;
    l2s_nxt = l2s_r;
    l2w_nxt = l2w_r;
    cfg_hit = 1'b0;
    if (cfg_valid) begin
      cfg_hit = 1'b1;
      unique case (cfg_index)
        tlc_pkg::CFG_BLOCK_BYTES_LOG2: blk_nxt = cfg_data[2:0];
        tlc_pkg::CFG_L1_SETS_LOG2:     l1s_nxt = cfg_data[2:0];
        tlc_pkg::CFG_L1_WAYS:          l1w_nxt = cfg_data;
        tlc_pkg::CFG_L2_SETS_LOG2:     l2s_nxt = cfg_data[3:0];
        tlc_pkg::CFG_L2_WAYS:          l2w_nxt = cfg_data;
        default:                       cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= tlc_pkg::RST_BLOCK_BYTES_LOG2;
      l1s_r <= tlc_pkg::RST_L1_SETS_LOG2;
      l1w_r <= tlc_pkg::RST_L1_WAYS;
      l2s_r <= tlc_pkg::RST_L2_SETS_LOG2;
      l2w_r <= tlc_pkg::RST_L2_WAYS;
    end else begin
      blk_r <= blk_nxt;
      l1s_r <= l1s_nxt;
      l1w_r <= l1w_nxt;
      l2s_r <= l2s_nxt;
      l2w_r <= l2w_nxt;
    end
  end

  tlc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (l1_stat.busy || l2_stat.busy || cfg_hit),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_kind    (q_kind),
    .q_addr    (q_addr)
  );

  tlc_level #(.ADDR_BITS(ADDR_BITS), .LINES(L1_LINES), .MAX_WAYS(MAX_WAYS)) u_l1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_hit),
    .start      (l1_start),
    .req_write  (l1_write),
    .req_addr   (l1_addr),
    .block_log2 (blk_r),
    .sets_log2  ({1'b0, l1s_r}),
    .ways       (l1w_r),
    .stat       (l1_stat),
    .ev_addr    (l1_ev_addr)
  );

  tlc_level #(.ADDR_BITS(ADDR_BITS), .LINES(L2_LINES), .MAX_WAYS(MAX_WAYS)) u_l2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_hit),
    .start      (l2_start),
    .req_write  (l2_write),
    .req_addr   (l2_addr),
    .block_log2 (blk_r),
    .sets_log2  (l2s_r),
    .ways       (l2w_r),
    .stat       (l2_stat),
    .ev_addr    (l2_ev_addr)
  );

  tlc_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_kind     (q_kind),
    .q_addr     (q_addr),
    .q_pop      (q_pop),
    .l1_start   (l1_start),
    .l1_write   (l1_write),
    .l1_addr    (l1_addr),
    .l1_stat    (l1_stat),
    .l1_ev_addr (l1_ev_addr),
    .l2_start   (l2_start),
    .l2_write   (l2_write),
    .l2_addr    (l2_addr),
    .l2_stat    (l2_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/tlc_checker.sv
module tlc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An L1 hit touches nothing else and costs one ns
  a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[17:1] == {10'd1, 7'd0})
    else $error("L1 hit with L2 activity");

  // An L1 miss makes exactly one L2 read
  a_miss_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[2] ^ out_tdata[3]))
    else $error("L1 miss without a single L2 read");

  // A victim writeback shows as exactly one L2 write outcome
  a_wb_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[4] | out_tdata[5]) == out_tdata[1]) &&
                   !(out_tdata[4] && out_tdata[5]))
    else $error("L2 write flags disagree with L1 writeback");

endmodule

bind two_level_lru_writeback_cache_unit tlc_checker u_tlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/two_level_lru_writeback_cache_unit_test.sv
`timescale 1ns / 1ps

module two_level_lru_writeback_cache_unit_test;

  localparam int  L1_LINES   = 128;
  localparam int  L2_LINES   = 8192;
  localparam int  MAX_WAYS   = 16;
  localparam int  CYCLE_CAP  = 1500000;
  localparam int  DRAIN_WAIT = 150;
  localparam bit  KIND_READ  = 1'b0;
  localparam bit  KIND_WRITE = 1'b1;
  localparam int  LVL_1      = 0;
  localparam int  LVL_2      = 1;

  // Result fields, highest first so the struct lines up with out_tdata[17:0]
  typedef struct packed {
    logic [9:0] time_ns;
    logic [1:0] l2_wbs;
    logic       wr_miss;
    logic       wr_hit;
    logic       rd_miss;
    logic       rd_hit;
    logic       l1_wb;
    logic       l1_hit;
  } cache_result_t;

  typedef struct {
    bit            kind;
    logic [31:0]   addr;
    bit            typed;
    cache_result_t res;
  } access_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [tlc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [tlc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data;

  two_level_lru_writeback_cache_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow tag state of both levels
  logic [31:0] tag_mem [2][L2_LINES];
  bit          line_vld [2][L2_LINES];
  bit          line_dirty [2][L2_LINES];
  logic [3:0]  line_age [2][L2_LINES];

  int unsigned line_bytes_log2, l1_sets_reg, l1_ways_reg, l2_sets_reg, l2_ways_reg;

  cache_result_t pending_results[$];
  access_row_t   sent_rows[$];
  int            err_count;
  int            cycle_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            hold_req;
  int            hold_left;
  logic [31:0]   hot_lines[16];

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up at the cycle cap
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, field, got, want);
    err_count++;
  endtask

  function automatic void invalidate_all();
    for (int lv = 0; lv < 2; lv++)
      for (int i = 0; i < L2_LINES; i++) begin
        line_vld[lv][i]   = 1'b0;
        line_dirty[lv][i] = 1'b0;
        line_age[lv][i]   = 4'd0;
      end
  endfunction

  function automatic void fit_geometry(input int unsigned sets_log2, ways, lines,
                                       output int unsigned s, w);
    int unsigned cap;
    s = sets_log2;
    while (s > 0 && (1 << s) > lines) s--;
    w = ways;
    if (w < 1) w = 1;
    if (w > MAX_WAYS) w = MAX_WAYS;
    cap = lines >> s;
    if (cap < 1) cap = 1;
    if (w > cap) w = cap;
  endfunction

  // Age every younger valid way, make the given way the youngest
  function automatic void refresh_age(input int lv, input int unsigned base, ways, way);
    int unsigned old_age;
    old_age = line_vld[lv][base+way] ? line_age[lv][base+way] : 16;
    for (int unsigned i = 0; i < ways; i++)
      if (i != way && line_vld[lv][base+i] && line_age[lv][base+i] < old_age &&
          line_age[lv][base+i] < tlc_pkg::RANK_MAX)
        line_age[lv][base+i]++;
    line_age[lv][base+way] = 4'd0;
  endfunction

  // Search a set, install on a miss; returns the hit flag
  function automatic bit set_lookup(input int lv, input int unsigned base, ways,
                                    input logic [31:0] tag, input bit wr,
                                    output bit ev_dirty, output logic [31:0] ev_tag);
    int unsigned v;
    bit got_free;
    v = 0;
    got_free = 1'b0;
    ev_dirty = 1'b0;
    ev_tag = '0;
    for (int unsigned i = 0; i < ways; i++)
      if (line_vld[lv][base+i] && tag_mem[lv][base+i] == tag) begin
        refresh_age(lv, base, ways, i);
        if (wr) line_dirty[lv][base+i] = 1'b1;
        return 1'b1;
      end
    for (int unsigned i = 0; i < ways; i++)
      if (!got_free && !line_vld[lv][base+i]) begin
        v = i;
        got_free = 1'b1;
      end
    if (!got_free) begin
      for (int unsigned i = 1; i < ways; i++)
        if (line_age[lv][base+i] > line_age[lv][base+v]) v = i;
      ev_dirty = line_dirty[lv][base+v];
      ev_tag = tag_mem[lv][base+v];
    end
    refresh_age(lv, base, ways, v);
    tag_mem[lv][base+v] = tag;
    line_vld[lv][base+v] = 1'b1;
    line_dirty[lv][base+v] = wr;
    return 1'b0;
  endfunction

  function automatic bit l2_touch(input longint unsigned a, input bit wr,
                                  inout int unsigned wbs);
    int unsigned s, w;
    longint unsigned set_no;
    bit ed, hit;
    logic [31:0] et;
    fit_geometry(l2_sets_reg, l2_ways_reg, L2_LINES, s, w);
    set_no = (a >> line_bytes_log2) & ((64'd1 << s) - 1);
    hit = set_lookup(LVL_2, 32'(set_no * w), w, 32'(a >> (line_bytes_log2 + s)), wr,
                     ed, et);
    if (ed) wbs++;
    return hit;
  endfunction

  // Work out the result of one access and update the shadow state
  function automatic cache_result_t predict_access(input bit kind, input logic [31:0] addr);
    cache_result_t r;
    int unsigned s, w, wbs, l2n, memn, b;
    longint unsigned a, set_no, victim;
    bit ed, hit;
    logic [31:0] et;
    r = '0;
    wbs = 0;
    b = line_bytes_log2;
    a = addr;
    fit_geometry(l1_sets_reg, l1_ways_reg, L1_LINES, s, w);
    set_no = (a >> b) & ((64'd1 << s) - 1);
    hit = set_lookup(LVL_1, 32'(set_no * w), w, 32'(a >> (b + s)), kind, ed, et);
    victim = (longint'(et) << (b + s)) | (set_no << b) | (a & ((64'd1 << b) - 1));
    r.l1_hit = hit;
    r.l1_wb = ed;
    if (!hit) begin
      if (kind == KIND_WRITE) begin
        if (l2_touch(a, 1'b0, wbs)) r.rd_hit = 1'b1; else r.rd_miss = 1'b1;
        if (ed) begin
          if (l2_touch(victim, 1'b1, wbs)) r.wr_hit = 1'b1; else r.wr_miss = 1'b1;
        end
      end else begin
        if (ed) begin
          if (l2_touch(victim, 1'b1, wbs)) r.wr_hit = 1'b1; else r.wr_miss = 1'b1;
        end
        if (l2_touch(a, 1'b0, wbs)) r.rd_hit = 1'b1; else r.rd_miss = 1'b1;
      end
    end
    l2n = (r.rd_hit | r.rd_miss) + (r.wr_hit | r.wr_miss);
    memn = r.rd_miss + r.wr_miss + wbs;
    r.l2_wbs = wbs[1:0];
    r.time_ns = 10'(tlc_pkg::T_ACCESS + tlc_pkg::T_L2 * l2n + tlc_pkg::T_MEM * memn);
    return r;
  endfunction

  function automatic cache_result_t make_result(bit l1h, bit wb, bit rh, bit rm,
                                                bit wh, bit wm, int t);
    cache_result_t r;
    r = '0;
    r.l1_hit = l1h;
    r.l1_wb = wb;
    r.rd_hit = rh;
    r.rd_miss = rm;
    r.wr_hit = wh;
    r.wr_miss = wm;
    r.time_ns = 10'(t);
    return r;
  endfunction

  // Predict each accepted access; directed rows may carry a typed result
  always @(posedge clk) begin
    cache_result_t r;
    access_row_t row;
    if (rst_n && in_tvalid && in_tready) begin
      r = predict_access(in_tuser, in_tdata);
      row = sent_rows.pop_front();
      pending_results.push_back(row.typed ? row.res : r);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    cache_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[17:0];
      if (pending_results.size() == 0) begin
        $display("[%0d] result with nothing expected", cycle_count);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.l1_hit  !== want.l1_hit)  report_mismatch("l1_hit", got.l1_hit, want.l1_hit);
        if (got.l1_wb   !== want.l1_wb)   report_mismatch("l1_writeback", got.l1_wb, want.l1_wb);
        if (got.rd_hit  !== want.rd_hit)  report_mismatch("l2_read_hit", got.rd_hit, want.rd_hit);
        if (got.rd_miss !== want.rd_miss) report_mismatch("l2_read_miss", got.rd_miss, want.rd_miss);
        if (got.wr_hit  !== want.wr_hit)  report_mismatch("l2_write_hit", got.wr_hit, want.wr_hit);
        if (got.wr_miss !== want.wr_miss)
          report_mismatch("l2_write_miss", got.wr_miss, want.wr_miss);
        if (got.l2_wbs  !== want.l2_wbs)  report_mismatch("l2_writebacks", got.l2_wbs, want.l2_wbs);
        if (got.time_ns !== want.time_ns)
          report_mismatch("access_time_ns", got.time_ns, want.time_ns);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0 || sent_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [tlc_pkg::CFG_IDX_W-1:0] idx,
                                input int unsigned val);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= tlc_pkg::CFG_DATA_W'(val);
    @(posedge clk iff (cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    // Mirror the register update and the invalidation
    case (idx)
      tlc_pkg::CFG_BLOCK_BYTES_LOG2: line_bytes_log2 = val & 7;
      tlc_pkg::CFG_L1_SETS_LOG2:     l1_sets_reg = val & 7;
      tlc_pkg::CFG_L1_WAYS:          l1_ways_reg = val & 31;
      tlc_pkg::CFG_L2_SETS_LOG2:     l2_sets_reg = val & 15;
      tlc_pkg::CFG_L2_WAYS:          l2_ways_reg = val & 31;
      default:                       return;
    endcase
    invalidate_all();
  endtask

  task automatic set_geometry(int unsigned b, s1, w1, s2, w2);
    write_register(tlc_pkg::CFG_BLOCK_BYTES_LOG2, b);
    write_register(tlc_pkg::CFG_L1_SETS_LOG2, s1);
    write_register(tlc_pkg::CFG_L1_WAYS, w1);
    write_register(tlc_pkg::CFG_L2_SETS_LOG2, s2);
    write_register(tlc_pkg::CFG_L2_WAYS, w2);
  endtask

  // Offer one access and hold it until the transaction completes
  task automatic send_access(input access_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    sent_rows.push_back(row);
    in_tvalid <= 1'b1;
    in_tdata  <= row.addr;
    in_tuser  <= row.kind;
    @(posedge clk iff (in_tvalid && in_tready));
  endtask

  // Mostly a small pool of lines so that sets fill and evict; some noise
  task automatic random_phase(input int count, input int pause_at);
    access_row_t row;
    for (int i = 0; i < 16; i++) hot_lines[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
      row.kind = $urandom_range(1);
      row.typed = 1'b0;
      row.res = '0;
      if ($urandom_range(99) < 75)
        row.addr = hot_lines[$urandom_range(15)] ^ ($urandom & 32'h7F);
      else
        row.addr = $urandom;
      send_access(row);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    access_row_t rows[$];
    access_row_t row;
    err_count = 0;
    cycle_count = 0;
    hold_req = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    line_bytes_log2 = tlc_pkg::RST_BLOCK_BYTES_LOG2;
    l1_sets_reg = tlc_pkg::RST_L1_SETS_LOG2;
    l1_ways_reg = tlc_pkg::RST_L1_WAYS;
    l2_sets_reg = tlc_pkg::RST_L2_SETS_LOG2;
    l2_ways_reg = tlc_pkg::RST_L2_WAYS;
    invalidate_all();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed accesses on the reset geometry: 64-byte lines, 8x2 L1
    rows.push_back('{KIND_READ,  32'h0000_0000, 1'b1, make_result(0, 0, 0, 1, 0, 0, 221)});
    rows.push_back('{KIND_WRITE, 32'h0000_0004, 1'b1, make_result(1, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{KIND_READ,  32'hFFFF_FFFF, 1'b1, make_result(0, 0, 0, 1, 0, 0, 221)});
    rows.push_back('{KIND_WRITE, 32'h0000_0200, 1'b1, make_result(0, 0, 0, 1, 0, 0, 221)});
    // Dirty victim on a read miss goes to L2 first
    rows.push_back('{KIND_READ,  32'h0000_0400, 1'b1, make_result(0, 1, 0, 1, 1, 0, 241)});
    // Dirty victim on a write miss goes to L2 after the read
    rows.push_back('{KIND_WRITE, 32'h0000_0600, 1'b1, make_result(0, 1, 0, 1, 1, 0, 241)});
    foreach (rows[i]) send_access(rows[i]);
    // Remaining directed rows: extremes and set reuse, checked by prediction
    row.typed = 1'b0;
    row.res = '0;
    for (int i = 0; i < 14; i++) begin
      row.kind = i[0];
      case (i / 2)
        0: row.addr = 32'h8000_0000;
        1: row.addr = 32'h7FFF_FFFF;
        2: row.addr = 32'hAAAA_AAAA;
        3: row.addr = 32'h5555_5555;
        4: row.addr = 32'h0000_0800;
        5: row.addr = 32'h0000_0A00;
        default: row.addr = 32'h0000_0400;
      endcase
      send_access(row);
    end

    random_phase(60, -1);

    // Smallest geometry, idle sender
    send_idle_pct = 54;
    set_geometry(3, 0, 1, 0, 1);
    random_phase(70, -1);

    // Largest set counts, ways clamped down, stalling receiver
    send_idle_pct = 0;
    recv_stall_pct = 54;
    set_geometry(7, 7, 16, 13, 16);
    random_phase(60, -1);

    // One-byte lines, oversized and zero ways, both sides idling
    send_idle_pct = 29;
    recv_stall_pct = 29;
    set_geometry(0, 2, 31, 15, 0);
    write_register(3'd7, 5'd9);
    random_phase(70, -1);

    // Small odd geometry; receiver holds off while the sender keeps going
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_geometry(4, 1, 4, 2, 3);
    hold_req = 1'b1;
    random_phase(70, -1);

    // Largest L1 way count, then a drain in the middle
    send_idle_pct = 29;
    recv_stall_pct = 29;
    set_geometry(5, 3, 16, 4, 16);
    random_phase(70, 35);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
